// File: src/particle_boundary_ghost_generator_macros.svh
// assertion helpers for the boundary ghost generator checker
`ifndef PARTICLE_BOUNDARY_GHOST_GENERATOR_MACROS_SVH
`define PARTICLE_BOUNDARY_GHOST_GENERATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define PBG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbg check failed");

// next-cycle implication, disabled in reset
`define PBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbg check failed");

`endif

// File: src/pbg_pkg.sv
`timescale 1ns / 1ps
package pbg_pkg;

    // input word: one particle
    typedef struct packed {
        logic [15:0]        particle_index;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic               final_particle;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [15:0]        source_index;
        logic signed [31:0] new_position;
        logic signed [31:0] new_velocity;
        logic               is_ghost;
        logic               crossed_error;
        logic               last_of_run;
        logic               end_of_set;
    } t_out_word;

    // edge rule codes; code three acts as free
    typedef enum logic [1:0] {
        MODE_FREE     = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_STATIC   = 2'd2
    } t_edge_mode;

    // register word index on the config port
    typedef enum logic [2:0] {
        REG_EDGE_MODE  = 3'd0,
        REG_EDGE_SIDE  = 3'd1,
        REG_LOWER_EDGE = 3'd2,
        REG_UPPER_EDGE = 3'd3,
        REG_BAND_WIDTH = 3'd4
    } t_reg_idx;

    localparam logic SIDE_LOWER = 1'b0;
    localparam logic SIDE_UPPER = 1'b1;

    localparam logic signed [31:0] UPPER_EDGE_RESET = 32'sd65536;

    // clamp a 35-bit intermediate to Q16.16 range
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            r = v[31:0];
        end else if (v[34]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// File: src/particle_boundary_ghost_generator.sv
`timescale 1ns / 1ps
// Applies one domain-edge rule (free, periodic wrap or static mirror, at the lower or
// upper edge) to a stream of particles in Q16.16 and emits the updated particle, then
// a ghost copy when the particle sits in the band at the edge. An input word gives a
// single result, or a result and then its ghost; the single output port sends one
// result word per cycle while i_out_stall is low. The rule works on the input
// register r_in, results go to r_ow and the ghost waits in r_pw. APB register writes
// must come only while no particle is in flight; the block does not enforce this.
module particle_boundary_ghost_generator
    import pbg_pkg::*;
#(
    parameter int MAX_PARTICLES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // particle input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_CMP_W = 25;
    localparam logic [IDX_CMP_W-1:0] IDX_LIMIT = IDX_CMP_W'(MAX_PARTICLES);

    // config registers
    logic [1:0]         r_edge_mode;
    logic               r_edge_side;
    logic signed [31:0] r_lower_edge;
    logic signed [31:0] r_upper_edge;
    logic [30:0]        r_band_width;

    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_mode  <= 2'(MODE_FREE);
            r_edge_side  <= SIDE_LOWER;
            r_lower_edge <= '0;
            r_upper_edge <= UPPER_EDGE_RESET;
            r_band_width <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_EDGE_MODE:  r_edge_mode  <= pwdata[1:0];
                REG_EDGE_SIDE:  r_edge_side  <= pwdata[0];
                REG_LOWER_EDGE: r_lower_edge <= pwdata;
                REG_UPPER_EDGE: r_upper_edge <= pwdata;
                REG_BAND_WIDTH: r_band_width <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (reg_idx)
            REG_EDGE_MODE:  prdata = {30'd0, r_edge_mode};
            REG_EDGE_SIDE:  prdata = {31'd0, r_edge_side};
            REG_LOWER_EDGE: prdata = r_lower_edge;
            REG_UPPER_EDGE: prdata = r_upper_edge;
            REG_BAND_WIDTH: prdata = {1'b0, r_band_width};
            default:        prdata = '0;
        endcase
    end

    // input register
    logic     r_iv;
    t_in_word r_in;
    logic     load;

    // output register, plus the ghost word waiting behind it
    logic      r_ov;
    t_out_word r_ow;
    logic      r_pend;
    t_out_word r_pw;
    logic      out_take;

    assign out_take    = r_ov && !i_out_stall;
    assign load        = r_iv && (!r_ov || (out_take && !r_pend));
    assign o_in_stall  = r_iv && !load;
    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_iv <= 1'b1;
        end else if (load) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    // edge rule on the registered word
    logic signed [34:0] x, v, xl, xr, dx, len, e;
    logic signed [34:0] lo_m, lo_p, hi_m, hi_p;
    logic signed [34:0] x_add, x_sub, refl, neg_v;
    logic signed [31:0] s_add, s_sub, s_refl, s_neg;
    logic               in_store;
    t_out_word          res0, res1;
    logic               two;

    always_comb begin
        x     = 35'(r_in.position);
        v     = 35'(r_in.velocity);
        xl    = 35'(r_lower_edge);
        xr    = 35'(r_upper_edge);
        dx    = {4'd0, r_band_width};
        len   = xr - xl;
        e     = (r_edge_side == SIDE_UPPER) ? xr : xl;
        lo_m  = xl - dx;
        lo_p  = xl + dx;
        hi_m  = xr - dx;
        hi_p  = xr + dx;
        x_add = x + len;
        x_sub = x - len;
        refl  = (e <<< 1) - x;
        neg_v = -v;
        s_add  = sat32(x_add);
        s_sub  = sat32(x_sub);
        s_refl = sat32(refl);
        s_neg  = sat32(neg_v);
        in_store = {9'd0, r_in.particle_index} < IDX_LIMIT;

        res0.source_index  = r_in.particle_index;
        res0.new_position  = r_in.position;
        res0.new_velocity  = r_in.velocity;
        res0.is_ghost      = 1'b0;
        res0.crossed_error = 1'b0;
        res0.last_of_run   = 1'b0;
        res0.end_of_set    = 1'b0;
        res1               = res0;
        res1.is_ghost      = 1'b1;
        two                = 1'b0;

        if (in_store) begin
            case (t_edge_mode'(r_edge_mode))
                MODE_PERIODIC: begin
                    if (r_edge_side == SIDE_LOWER) begin
                        if (x < lo_m) begin
                            res0.new_position = s_add;
                        end else if (x <= xl) begin
                            res0.new_position = s_add;
                            two = 1'b1;
                        end else if (x >= hi_m && x <= xr) begin
                            res1.new_position = s_sub;
                            two = 1'b1;
                        end
                    end else begin
                        if (x > hi_p) begin
                            res0.new_position = s_sub;
                        end else if (x >= xr) begin
                            res0.new_position = s_sub;
                            two = 1'b1;
                        end else if (x <= lo_p && x >= xl) begin
                            res1.new_position = s_add;
                            two = 1'b1;
                        end
                    end
                end
                MODE_STATIC: begin
                    if (r_edge_side == SIDE_LOWER) begin
                        if (x < lo_m) begin
                            res0.crossed_error = 1'b1;
                        end else if (x < xl) begin
                            res0.new_position = s_refl;
                            res0.new_velocity = s_neg;
                            two = 1'b1;
                        end else if (x <= lo_p) begin
                            res1.new_position = s_refl;
                            res1.new_velocity = s_neg;
                            two = 1'b1;
                        end
                    end else begin
                        if (x > hi_p) begin
                            res0.crossed_error = 1'b1;
                        end else if (x > xr) begin
                            res0.new_position = s_refl;
                            res0.new_velocity = s_neg;
                            two = 1'b1;
                        end else if (x >= hi_m) begin
                            res1.new_position = s_refl;
                            res1.new_velocity = s_neg;
                            two = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end

        // mark the last word of this particle
        res1.last_of_run = 1'b1;
        res1.end_of_set  = r_in.final_particle;
        if (!two) begin
            res0.last_of_run = 1'b1;
            res0.end_of_set  = r_in.final_particle;
        end
    end

    // output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
        end else if (load) begin
            r_ov   <= 1'b1;
            r_pend <= two;
        end else if (out_take) begin
            r_ov   <= r_pend;
            r_pend <= 1'b0;
        end
    end

    // output words
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ow <= res0;
            r_pw <= res1;
        end else if (out_take && r_pend) begin
            r_ow <= r_pw;
        end
    end

endmodule

// File: src/pbg_checker.sv
`timescale 1ns / 1ps
`include "particle_boundary_ghost_generator_macros.svh"
module pbg_checker
    import pbg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // a stalled result word holds
    `PBG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))

    // a taken word that is not the last one is followed at once by its ghost
    `PBG_ASSERT_NEXT(a_ghost_follows, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_out_word.last_of_run, o_out_valid && o_out_word.is_ghost && o_out_word.last_of_run)

    // a ghost is always the closing word and never flags an error
    `PBG_ASSERT_NOW(a_ghost_last, i_clk, i_rst_n, o_out_valid && o_out_word.is_ghost, o_out_word.last_of_run && !o_out_word.crossed_error)

    // end of set only rides on the last word
    `PBG_ASSERT_NOW(a_eos_last, i_clk, i_rst_n, o_out_valid && o_out_word.end_of_set, o_out_word.last_of_run)

endmodule

bind particle_boundary_ghost_generator pbg_checker u_pbg_checker (.*);
